// ===== hw/rtl/bldq_pkg.sv =====
// shared constants for the bounded list deque: capacity default, operation and status codes
// no dependencies
`default_nettype none
package bldq_pkg;
  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_DEL_VALUE = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned WORD_W = 32;
endpackage
`default_nettype wire

// ===== hw/rtl/bounded_list_deque_with_value_delete.sv =====
// Bounded ordered list of unsigned words kept as a circular buffer in one ram.
//
// Input channel (in_*): one transaction per request. in_tuser carries the
// operation (insert front, insert back, delete value, delete front, delete
// back), in_tdata the word. Output channel (out_*): exactly one transaction
// per request with status in out_tuser and removed word, count, front and
// back words in out_tdata.
// Inserts and no-ops go straight to the front/back reads (RDF, RDB, RDW)
// and load the result (FIN); delete front/back first read the removed
// entry (POP); delete value searches (SRCH) one entry per cycle through
// the single ram read port, then moves the entries behind the hit down one
// per cycle (SHIFT), so each entry is visited once. When the list is empty
// afterwards the front/back reads are skipped. One request is in flight at
// a time; in_tready is high only while the sequencer is idle, so the next
// request is taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous) empties the list; ram contents are not
// cleared, entries are only read after being written. If the receiver
// stalls, the result is held in the output register and the sequencer waits
// before loading the next result.
`default_nettype none
module bounded_list_deque_with_value_delete
  import bldq_pkg::*;
#(
  parameter int unsigned CAPACITY = bldq_pkg::CAPACITY_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // value[31:0]
  input  wire logic [2:0]   in_tuser,   // mode[2:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // removed_value[31:0], count[36:32],
                                        // front_value[68:37], back_value[100:69], zero pad
  output logic [1:0]        out_tuser   // status[1:0]
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RDF   = 3'd4;
  localparam logic [2:0] S_RDB   = 3'd5;
  localparam logic [2:0] S_RDW   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [31:0]       value_r, value_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [31:0]       removed_r, removed_nxt;
  logic [31:0]       front_r, front_nxt;
  logic [31:0]       back_r, back_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic              oval_r, oval_nxt;
  logic [103:0]      odata_r, odata_nxt;
  logic [1:0]        ouser_r, ouser_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [31:0]       wdata, rdata;
  logic [CW-1:0]     k1;
  logic [CW+4:0]     cnt_ext;

  // slot of the entry at offset off from the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  bldq_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign k1        = CW'(k_r) + CW'(1);
  assign cnt_ext   = (CW+5)'(cnt_r);
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    value_nxt   = value_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    front_nxt   = front_r;
    back_nxt    = back_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    oval_nxt    = oval_r;
    odata_nxt   = odata_r;
    ouser_nxt   = ouser_r;
    we          = 1'b0;
    waddr       = head_r;
    wdata       = value_r;
    raddr       = head_r;

    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt    = in_tuser;
          value_nxt   = in_tdata;
          status_nxt  = ST_OK;
          removed_nxt = '0;
          k_nxt       = '0;
          state_nxt   = S_RDF;
          case (in_tuser)
            OP_INS_FRONT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
                we       = 1'b1;
                waddr    = head_nxt;
                wdata    = in_tdata;
                cnt_nxt  = cnt_r + CW'(1);
              end
            end
            OP_INS_BACK: begin
              if (cnt_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = phys(head_r, cnt_r);
                wdata   = in_tdata;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_DEL_VALUE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                raddr     = head_r;
                state_nxt = S_SRCH;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                raddr     = (in_tuser == OP_DEL_FRONT) ? head_r : phys(head_r, cnt_r - CW'(1));
                state_nxt = S_POP;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        removed_nxt = rdata;
        if (mode_r == OP_DEL_FRONT) begin
          head_nxt = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);
        end
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_RDF;
      end
      S_SRCH: begin
        // rdata holds the entry at offset k
        if (rdata == value_r) begin
          removed_nxt = rdata;
          if (k1 == cnt_r) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_RDF;
          end else begin
            raddr     = phys(head_r, k1);
            state_nxt = S_SHIFT;
          end
        end else if (k1 == cnt_r) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_RDF;
        end else begin
          raddr = phys(head_r, k1);
          k_nxt = k_r + AW'(1);
        end
      end
      S_SHIFT: begin
        // move entry k+1 down into slot k
        we    = 1'b1;
        waddr = phys(head_r, CW'(k_r));
        wdata = rdata;
        if (k1 + CW'(1) == cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_RDF;
        end else begin
          raddr = phys(head_r, k1 + CW'(1));
          k_nxt = k_r + AW'(1);
        end
      end
      S_RDF: begin
        if (cnt_r == '0) begin
          front_nxt = '0;
          back_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          raddr     = head_r;
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        front_nxt = rdata;
        raddr     = phys(head_r, cnt_r - CW'(1));
        state_nxt = S_RDW;
      end
      S_RDW: begin
        back_nxt  = rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!oval_r || out_tready) begin
          oval_nxt  = 1'b1;
          ouser_nxt = status_r;
          odata_nxt = {3'b000, back_r, front_r, cnt_ext[4:0], removed_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      k_r     <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      oval_r  <= oval_nxt;
    end
    mode_r    <= mode_nxt;
    value_r   <= value_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    front_r   <= front_nxt;
    back_r    <= back_nxt;
    odata_r   <= odata_nxt;
    ouser_r   <= ouser_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bldq_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none
module bldq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bldq_chk.sv =====
// port-level checker for the bounded list deque, bound to the top level
// depends on bldq_pkg for status codes
`default_nettype none
module bldq_chk
  import bldq_pkg::*;
#(
  parameter int unsigned CAPACITY = bldq_pkg::CAPACITY_DEF
) (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [31:0]  in_tdata,
  input wire logic [2:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata,
  input wire logic [1:0]   out_tuser
);
  localparam logic [4:0] CAP5 = 5'(CAPACITY);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result transaction changed");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[36:32] == CAP5)
    else $error("full status with count below capacity");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[36:32] == 5'd0 &&
    out_tdata[100:37] == '0 && out_tdata[31:0] == '0)
    else $error("empty status on a non-empty result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");
endmodule

bind bounded_list_deque_with_value_delete bldq_chk #(.CAPACITY(CAPACITY)) u_bldq_chk (.*);
`default_nettype wire
